FILE: src/best_fit_heap_allocator_top_assert.svh
// Assertion macros for the best-fit heap allocator.
// Included by the top level; needs clk and rst in scope.
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define BFHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BFHA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: src/bfha_pkg.sv
// Package for the best-fit heap allocator: status codes, ops, default sizes.
// No dependencies.
package bfha_pkg;
  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int MAX_SEG_DEF      = 64;
  localparam int HEADER_BYTES_DEF = 20;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADALIGN = 2'd3;

  localparam int SEG_W = 86;  // start 32, size 21, used 1, pointer 32

  typedef struct packed {
    logic [31:0] start;
    logic [20:0] size;
    logic        used;
    logic [31:0] ptr;
  } seg_t;
endpackage

FILE: src/bfha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/best_fit_heap_allocator_top.sv
// Best-fit heap allocator: segment table in one RAM, scanned by a sequencer.
// Depends on bfha_pkg, bfha_ram and best_fit_heap_allocator_top_assert.svh.
`include "best_fit_heap_allocator_top_assert.svh"
// An item takes one pass over the valid table entries, a cycle per entry (one
// RAM read port), plus a shift pass when a split inserts or a free merges
// entries (a cycle per moved entry). After reset the S_INIT state writes
// entry zero before the input opens; a reinitialise rewrites entry zero and
// resets the entry count. The result waits in an output register while the
// next item is taken in; a finished result that finds that register still
// full holds the sequencer. heap_base takes effect at the next reinitialise;
// reset clears it to zero.
module best_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
  parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEG_DEF,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], req_bytes[22:2], align_bytes[38:23], free_addr[70:39], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_addr[31:0], status[33:32], zero fill
  output logic [39:0] m_axis_tdata
);
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
  localparam logic [21:0] HDR = 22'(HEADER_BYTES);
  localparam logic [21:0] HDR2 = 22'(2 * HEADER_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // read entries, find candidate
  localparam logic [3:0] S_DEC   = 4'd2;  // decide after scan
  localparam logic [3:0] S_UPSH  = 4'd3;  // shift entries up for a split
  localparam logic [3:0] S_SPLIT = 4'd4;  // write the two halves
  localparam logic [3:0] S_INIT  = 4'd5;  // write entry zero after reset
  localparam logic [3:0] S_FMRG  = 4'd7;  // write merged entry
  localparam logic [3:0] S_DNSH  = 4'd8;  // shift entries down after a merge
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]  state;
  logic [31:0] heap_base;
  logic [CW-1:0] seg_count;
  logic [1:0]  op;
  logic [20:0] req;
  logic [15:0] align;
  logic [31:0] fptr;
  logic [CW-1:0] idx;      // address sent to RAM this cycle
  logic [CW-1:0] ridx;     // index of data on rdata
  logic        rvld;
  logic        found;
  logic [AW-1:0] best;
  logic [21:0] min_slack;
  logic        do_split;
  bfha_pkg::seg_t best_seg;
  bfha_pkg::seg_t prev_seg;  // entry just before current scan entry
  logic        prev_free;
  bfha_pkg::seg_t nxt_seg;
  logic        nxt_ok;
  logic [CW-1:0] gap_n;    // entries removed
  logic [31:0] res_addr;
  logic [1:0]  res_st;
  logic        out_full;
  logic [31:0] out_addr;
  logic [1:0]  out_st;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  bfha_pkg::seg_t wdata, rdata;

  bfha_ram #(.WIDTH(bfha_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [21:0] need;
  logic        bad_align;
  logic [21:0] first;
  logic [21:0] diff;
  logic [31:0] amask;
  logic        split_ok;
  assign need = HDR + 22'(align) + 22'(req);
  assign first = (need + 22'd7) & ~22'd7;
  assign bad_align = (align == 16'd0) || ((align & (align - 16'd1)) != 16'd0);
  assign diff = 22'(rdata.size) - need;
  assign amask = {16'd0, align - 16'd1};
  assign split_ok = (min_slack > HDR2) && (seg_count < MAXC);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {6'd0, out_st, out_addr};

  // Drive RAM accesses from the sequencer state
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[AW-1:0];
    unique case (state)
      S_INIT: begin
        we = 1'b1;
        wdata = '{start: heap_base, size: 21'(HEAP_BYTES), used: 1'b0, ptr: 32'd0};
      end
      S_UPSH: begin
        // copy entry sh-1 (on rdata) into sh
        we = rvld;
        waddr = ridx[AW-1:0] + AW'(1);
        wdata = rdata;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = best;
        wdata = best_seg;
        wdata.used = 1'b1;
        if (idx == CW'(1)) begin
          waddr = best + AW'(1);
          wdata.start = best_seg.start + 32'(first);
          wdata.size = best_seg.size - first[20:0];
          wdata.used = 1'b0;
          wdata.ptr = '0;
        end else begin
          if (do_split) begin
            wdata.size = first[20:0];
          end
          wdata.ptr = (best_seg.start + 32'(HDR) + amask) & ~amask;
        end
      end
      S_FMRG: begin
        we = 1'b1;
        waddr = best;
        wdata = best_seg;
      end
      S_DNSH: begin
        we = rvld;
        waddr = ridx[AW-1:0] - AW'(gap_n);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == S_DONE && (!out_full || m_axis_tready)) begin
      out_full <= 1'b1;
      out_addr <= res_addr;
      out_st <= res_st;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      heap_base <= '0;
      seg_count <= CW'(1);
      rvld <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_base <= cfg_wdata;
      end
      ridx <= idx;
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          rvld <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[1:0];
            req <= s_axis_tdata[22:2];
            align <= s_axis_tdata[38:23];
            fptr <= s_axis_tdata[70:39];
            idx <= '0;
            found <= 1'b0;
            prev_free <= 1'b0;
            res_addr <= '0;
            res_st <= bfha_pkg::ST_OK;
            if (s_axis_tdata[1:0] == bfha_pkg::OP_ALLOC
                || s_axis_tdata[1:0] == bfha_pkg::OP_FREE) begin
              state <= S_SCAN;
            end else begin
              if (s_axis_tdata[1:0] == bfha_pkg::OP_REINIT) begin
                // entry 0 written through the single-entry fast path
                seg_count <= CW'(1);
                best <= '0;
                best_seg <= '{start: heap_base, size: 21'(HEAP_BYTES),
                              used: 1'b0, ptr: 32'd0};
                state <= S_FMRG;
                gap_n <= '0;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_SCAN: begin
          // Issue reads, evaluate returned entries
          rvld <= idx < seg_count;
          if (idx < seg_count) begin
            idx <= idx + CW'(1);
          end
          if (rvld) begin
            if (op == bfha_pkg::OP_ALLOC) begin
              if (!rdata.used && 22'(rdata.size) >= need
                  && (!found || diff < min_slack)) begin
                found <= 1'b1;
                best <= ridx[AW-1:0];
                min_slack <= diff;
                best_seg <= rdata;
              end
            end else if (!found) begin
              if (rdata.used && rdata.ptr == fptr) begin
                found <= 1'b1;
                nxt_ok <= 1'b0;
                if (prev_free) begin
                  // merge into previous entry
                  best <= ridx[AW-1:0] - AW'(1);
                  best_seg <= '{start: prev_seg.start, size: prev_seg.size + rdata.size,
                                used: 1'b0, ptr: 32'd0};
                  gap_n <= CW'(1);
                end else begin
                  best <= ridx[AW-1:0];
                  best_seg <= '{start: rdata.start, size: rdata.size,
                                used: 1'b0, ptr: 32'd0};
                  gap_n <= '0;
                end
              end else begin
                prev_seg <= rdata;
                prev_free <= !rdata.used;
              end
            end else if (!nxt_ok) begin
              // entry following the freed one
              nxt_ok <= 1'b1;
              nxt_seg <= rdata;
            end
          end
          if (!(idx < seg_count) && !rvld) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (op == bfha_pkg::OP_ALLOC) begin
            if (bad_align) begin
              res_st <= bfha_pkg::ST_BADALIGN;
              state <= S_DONE;
            end else if (!found) begin
              res_st <= bfha_pkg::ST_NOFIT;
              state <= S_DONE;
            end else begin
              res_addr <= (best_seg.start + 32'(HDR) + amask) & ~amask;
              do_split <= split_ok;
              if (split_ok) begin
                idx <= seg_count - CW'(1);
                state <= S_UPSH;
              end else begin
                idx <= '0;
                state <= S_SPLIT;
              end
            end
          end else if (!found) begin
            res_st <= bfha_pkg::ST_NOTFOUND;
            state <= S_DONE;
          end else begin
            if (nxt_ok && !nxt_seg.used) begin
              best_seg.size <= best_seg.size + nxt_seg.size;
              gap_n <= gap_n + CW'(1);
            end
            state <= S_FMRG;
          end
          rvld <= 1'b0;
        end
        S_UPSH: begin
          // move entries best+1 .. count-1 up by one, top first
          if (idx > CW'(best)) begin
            idx <= idx - CW'(1);
            rvld <= 1'b1;
          end else begin
            rvld <= 1'b0;
          end
          if (!(idx > CW'(best)) && (!rvld || ridx == CW'(best) + CW'(1))) begin
            idx <= CW'(1);
            seg_count <= seg_count + CW'(1);
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          // on a split the free rest is written first, then the allocated part
          if (idx == CW'(1)) begin
            idx <= '0;
          end else begin
            state <= S_DONE;
          end
        end
        S_FMRG: begin
          if (gap_n == '0) begin
            state <= S_DONE;
          end else begin
            idx <= CW'(best) + CW'(1) + gap_n;
            rvld <= 1'b0;
            state <= S_DNSH;
          end
        end
        S_DNSH: begin
          // move entries after the gap down, bottom first
          if (idx < seg_count) begin
            idx <= idx + CW'(1);
            rvld <= 1'b1;
          end else begin
            rvld <= 1'b0;
          end
          if (!(idx < seg_count) && !rvld) begin
            seg_count <= seg_count - gap_n;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register can take the result
          if (!out_full || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFHA_ASSERT(a_count_range, (seg_count != '0) && (seg_count <= MAXC), "count out of range")
  `BFHA_ASSERT(a_ready_idle, s_axis_tready |-> (state == S_IDLE), "input ready outside idle")
  `BFHA_ASSERT_NEXT(a_done_out, (state == S_DONE) && !out_full, out_full, "result not loaded")
endmodule
